>>> design/rbhd_pkg.sv
// Shared constants for the ray / box hit distance block.
// No dependencies; imported by design/ray_box_hit_distance.sv.
`timescale 1ns / 1ps

package rbhd_pkg;

   // coordinate and result widths
   localparam int COORD_W   = 32;
   localparam int DIST_W    = 31;
   localparam int CSR_IDX_W = 3;

   // hit-point offset saturates here, still outside any 32-bit coordinate
   localparam int OFF_W = 41;
   localparam logic [OFF_W-1:0] OFF_CLAMP = OFF_W'(1) << (OFF_W - 1);

   // hit point width: coordinate plus clamped offset, signed
   localparam int PT_W = OFF_W + 2;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_MAX_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_VALID = 3'd6;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

>>> design/ray_box_hit_distance.sv
// Ray / axis-aligned box hit distance, fully pipelined.
// Depends on rbhd_pkg (design/rbhd_pkg.sv).
`timescale 1ns / 1ps

// Usage
//   Program the box through the csr_ port (write enable, index, data) while no
//   transaction is in flight: min corner, max corner, then box_valid.
//   Issue a ray by raising start with the origin and direction on the req_
//   ports; it is taken at any clock edge where start is high and busy is low.
//   busy is high only during reset, so one ray can enter every cycle.
//   Each ray yields one transaction on the rsp_ ports: rsp_strobe is high for
//   exactly one cycle with rsp_hit and rsp_hit_distance (unsigned, FRAC_BITS
//   fraction bits, saturated at 2^31-1, zero on a miss or an inside origin).
// Pipeline and throughput
//   The pipeline is a front capture register, the restoring divider with one
//   quotient bit per stage over FRAC_BITS + 33 stages, a split multiply, a
//   sum/saturate stage, a hit-point compare stage and the nearest-face
//   select into the output register. Throughput is one ray per cycle.
// Reset and flow
//   Synchronous reset clears all pipeline valid bits and the box registers
//   (box invalid). The receiver cannot stall; results are never held back.
module ray_box_hit_distance #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  rbhd_pkg::coord_type                   req_origin_x,
   input  rbhd_pkg::coord_type                   req_origin_y,
   input  rbhd_pkg::coord_type                   req_origin_z,
   input  rbhd_pkg::coord_type                   req_dir_x,
   input  rbhd_pkg::coord_type                   req_dir_y,
   input  rbhd_pkg::coord_type                   req_dir_z,
   input  logic                                  csr_write,
   input  logic [rbhd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rbhd_pkg::COORD_W-1:0]          csr_wdata,
   output logic                                  rsp_strobe,
   output logic                                  rsp_hit,
   output logic [rbhd_pkg::DIST_W-1:0]           rsp_hit_distance
);
   import rbhd_pkg::*;

   localparam int QW = COORD_W + 1 + FRAC_BITS;  // quotient / dividend width
   localparam int RW = COORD_W;                  // remainder width
   localparam int AW = RW + QW;                  // divider working register
   localparam int HW = QW / 2;                   // low slice of the quotient
   localparam int QH = QW - HW;                  // high slice of the quotient
   localparam int PW = QW + COORD_W;             // full product width

   // box registers
   coord_type box_min_ff [3];
   coord_type box_max_ff [3];
   logic      box_valid_ff;

   // front stage
   logic      f_vld_ff;
   coord_type f_o_ff [3];
   coord_type f_d_ff [3];

   // divider pipeline, stage 0 loaded from the front stage
   logic                dv_vld_ff  [QW+1];
   logic                dv_in_ff   [QW+1];
   logic                dv_cand_ff [QW+1][3];
   coord_type           dv_o_ff    [QW+1][3];
   coord_type           dv_d_ff    [QW+1][3];
   logic [COORD_W-1:0]  dv_dm_ff   [QW+1][3];
   logic [AW-1:0]       dv_acc_ff  [QW+1][3];
   logic [AW-1:0]       dv_acc_in  [QW][3];

   // front combinational results
   logic                f_in_all;
   logic                f_cand [3];
   logic [COORD_W-1:0]  f_dm   [3];
   logic [COORD_W:0]    f_num  [3];

   // multiply stage
   logic                m1_vld_ff, m1_in_ff;
   logic                m1_cand_ff [3];
   logic [QW-1:0]       m1_q_ff    [3];
   coord_type           m1_o_ff    [3];
   coord_type           m1_d_ff    [3];
   logic [HW+COORD_W-1:0] m1_plo_ff [3][2];
   logic [QH+COORD_W-1:0] m1_phi_ff [3][2];

   // sum / saturate stage
   logic                m2_vld_ff, m2_in_ff;
   logic                m2_cand_ff [3];
   logic [QW-1:0]       m2_q_ff    [3];
   coord_type           m2_o_ff    [3];
   coord_type           m2_d_ff    [3];
   logic [OFF_W-1:0]    m2_off_ff  [3][2];
   logic [OFF_W-1:0]    m2_off_in  [3][2];

   // hit-point check stage
   logic                m3_vld_ff, m3_in_ff;
   logic                m3_pass_ff [3];
   logic [QW-1:0]       m3_q_ff    [3];
   logic                m3_pass_in [3];

   // output registers
   logic                rsp_strobe_ff, rsp_hit_ff;
   logic [DIST_W-1:0]   rsp_dist_ff;
   logic                sel_found;
   logic [QW-1:0]       sel_best;
   logic                rsp_hit_in;
   logic [DIST_W-1:0]   rsp_dist_in;

   assign busy = reset;

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_min_ff[a] <= '0;
            box_max_ff[a] <= '0;
         end
         box_valid_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BOX_MIN_X: box_min_ff[0] <= csr_wdata;
            CSR_BOX_MIN_Y: box_min_ff[1] <= csr_wdata;
            CSR_BOX_MIN_Z: box_min_ff[2] <= csr_wdata;
            CSR_BOX_MAX_X: box_max_ff[0] <= csr_wdata;
            CSR_BOX_MAX_Y: box_max_ff[1] <= csr_wdata;
            CSR_BOX_MAX_Z: box_max_ff[2] <= csr_wdata;
            CSR_BOX_VALID: box_valid_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // capture the transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= start;
      end
      f_o_ff[0] <= req_origin_x;
      f_o_ff[1] <= req_origin_y;
      f_o_ff[2] <= req_origin_z;
      f_d_ff[0] <= req_dir_x;
      f_d_ff[1] <= req_dir_y;
      f_d_ff[2] <= req_dir_z;
   end

   // inside test, approached face per axis, numerator and divisor magnitude
   always_comb begin
      f_in_all = 1'b1;
      for (int a = 0; a < 3; a++) begin
         logic lo_c, hi_c;
         lo_c = (f_o_ff[a] < box_min_ff[a]) && (f_d_ff[a] > 0);
         hi_c = (f_o_ff[a] > box_max_ff[a]) && (f_d_ff[a] < 0);
         f_in_all = f_in_all && (f_o_ff[a] >= box_min_ff[a]) &&
                    (f_o_ff[a] <= box_max_ff[a]);
         f_cand[a] = lo_c || hi_c;
         f_dm[a]   = f_d_ff[a][COORD_W-1] ? COORD_W'(-f_d_ff[a]) : f_d_ff[a];
         if (lo_c) begin
            f_num[a] = {box_min_ff[a][COORD_W-1], box_min_ff[a]} -
                       {f_o_ff[a][COORD_W-1], f_o_ff[a]};
         end else begin
            f_num[a] = {f_o_ff[a][COORD_W-1], f_o_ff[a]} -
                       {box_max_ff[a][COORD_W-1], box_max_ff[a]};
         end
      end
   end

   // one restoring quotient bit per stage
   always_comb begin
      for (int k = 0; k < QW; k++) begin
         for (int a = 0; a < 3; a++) begin
            logic [RW:0] t;
            logic        ge;
            logic [RW:0] r;
            t  = {dv_acc_ff[k][a][AW-1:QW], dv_acc_ff[k][a][QW-1]};
            ge = t >= {1'b0, dv_dm_ff[k][a]};
            r  = ge ? t - {1'b0, dv_dm_ff[k][a]} : t;
            dv_acc_in[k][a] = {r[RW-1:0], dv_acc_ff[k][a][QW-2:0], ge};
         end
      end
   end

   // advance the divider pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else begin
         dv_vld_ff[0] <= f_vld_ff;
         for (int k = 0; k < QW; k++) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end
      dv_in_ff[0] <= f_in_all;
      for (int a = 0; a < 3; a++) begin
         dv_cand_ff[0][a] <= f_cand[a];
         dv_o_ff[0][a]    <= f_o_ff[a];
         dv_d_ff[0][a]    <= f_d_ff[a];
         dv_dm_ff[0][a]   <= f_dm[a];
         dv_acc_ff[0][a]  <= {{RW{1'b0}}, f_num[a], {FRAC_BITS{1'b0}}};
      end
      for (int k = 0; k < QW; k++) begin
         dv_in_ff[k+1] <= dv_in_ff[k];
         for (int a = 0; a < 3; a++) begin
            dv_cand_ff[k+1][a] <= dv_cand_ff[k][a];
            dv_o_ff[k+1][a]    <= dv_o_ff[k][a];
            dv_d_ff[k+1][a]    <= dv_d_ff[k][a];
            dv_dm_ff[k+1][a]   <= dv_dm_ff[k][a];
            dv_acc_ff[k+1][a]  <= dv_acc_in[k][a];
         end
      end
   end

   // split products of the distance with the other two axes' magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= dv_vld_ff[QW];
      end
      m1_in_ff <= dv_in_ff[QW];
      for (int a = 0; a < 3; a++) begin
         m1_cand_ff[a] <= dv_cand_ff[QW][a];
         m1_q_ff[a]    <= dv_acc_ff[QW][a][QW-1:0];
         m1_o_ff[a]    <= dv_o_ff[QW][a];
         m1_d_ff[a]    <= dv_d_ff[QW][a];
         for (int j = 0; j < 2; j++) begin
            int b;
            b = (j == 0) ? ((a == 0) ? 1 : 0) : ((a == 2) ? 1 : 2);
            m1_plo_ff[a][j] <= (HW+COORD_W)'(dv_acc_ff[QW][a][HW-1:0]) *
                               (HW+COORD_W)'(dv_dm_ff[QW][b]);
            m1_phi_ff[a][j] <= (QH+COORD_W)'(dv_acc_ff[QW][a][QW-1:HW]) *
                               (QH+COORD_W)'(dv_dm_ff[QW][b]);
         end
      end
   end

   // join the partial products, drop fraction bits, clamp the offset
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int j = 0; j < 2; j++) begin
            logic [PW-1:0] full;
            logic [PW-1:0] shr;
            full = (PW'(m1_phi_ff[a][j]) << HW) + PW'(m1_plo_ff[a][j]);
            shr  = full >> FRAC_BITS;
            m2_off_in[a][j] = (shr > PW'(OFF_CLAMP)) ? OFF_CLAMP : shr[OFF_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else begin
         m2_vld_ff <= m1_vld_ff;
      end
      m2_in_ff <= m1_in_ff;
      for (int a = 0; a < 3; a++) begin
         m2_cand_ff[a] <= m1_cand_ff[a];
         m2_q_ff[a]    <= m1_q_ff[a];
         m2_o_ff[a]    <= m1_o_ff[a];
         m2_d_ff[a]    <= m1_d_ff[a];
         for (int j = 0; j < 2; j++) begin
            m2_off_ff[a][j] <= m2_off_in[a][j];
         end
      end
   end

   // place the hit point on the other two axes and check it against the box
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic ok;
         ok = m2_cand_ff[a];
         for (int j = 0; j < 2; j++) begin
            int b;
            logic signed [PT_W-1:0] pt;
            b = (j == 0) ? ((a == 0) ? 1 : 0) : ((a == 2) ? 1 : 2);
            if (m2_d_ff[b][COORD_W-1]) begin
               pt = PT_W'(m2_o_ff[b]) - PT_W'(m2_off_ff[a][j]);
            end else begin
               pt = PT_W'(m2_o_ff[b]) + PT_W'(m2_off_ff[a][j]);
            end
            ok = ok && (pt >= PT_W'(box_min_ff[b])) && (pt <= PT_W'(box_max_ff[b]));
         end
         m3_pass_in[a] = ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_vld_ff <= 1'b0;
      end else begin
         m3_vld_ff <= m2_vld_ff;
      end
      m3_in_ff <= m2_in_ff;
      for (int a = 0; a < 3; a++) begin
         m3_pass_ff[a] <= m3_pass_in[a];
         m3_q_ff[a]    <= m2_q_ff[a];
      end
   end

   // nearest passing face, earlier axis kept on a tie
   always_comb begin
      sel_found = 1'b0;
      sel_best  = '0;
      for (int a = 0; a < 3; a++) begin
         if (m3_pass_ff[a] && (!sel_found || (m3_q_ff[a] < sel_best))) begin
            sel_found = 1'b1;
            sel_best  = m3_q_ff[a];
         end
      end
      rsp_hit_in  = box_valid_ff && (m3_in_ff || sel_found);
      rsp_dist_in = '0;
      if (box_valid_ff && !m3_in_ff && sel_found) begin
         rsp_dist_in = (sel_best > QW'(DIST_MAX)) ? DIST_MAX : sel_best[DIST_W-1:0];
      end
   end

   // drive the result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= m3_vld_ff;
      end
      rsp_hit_ff  <= rsp_hit_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_distance = rsp_dist_ff;

endmodule
